// ===== hw/rtl/ftaz_pkg.sv =====
package ftaz_pkg;

  localparam int AXIS_COUNT     = 6;
  localparam int AXIS_W         = 32;
  localparam int SCOUNT_W       = 16;
  localparam int TOL_W          = 31;
  localparam int THR_W          = 16;
  localparam int STABLE_W       = 17;
  localparam int ATTEMPT_W      = 18;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 31;
  localparam int ATTEMPT_MARGIN = 100;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT     = 2'd0,
    REG_STABLE_TOLERANCE = 2'd1,
    REG_ZERO_THRESHOLD   = 2'd2
  } cfg_reg_t;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef axis_t [AXIS_COUNT-1:0] axes_t;

  // per-lane findings toward the merge stage
  typedef struct packed {
    logic nonzero;
    logic far;
  } lane_stat_t;

  // merge stage commands toward the lanes
  typedef struct packed {
    logic upd_prev;
    logic cap_bias;
  } lane_ctl_t;

endpackage

// ===== hw/rtl/ftaz_if.sv =====
interface ftaz_sample_if;
  import ftaz_pkg::*;
  logic  valid;
  logic  ready;
  axis_t force_x;
  axis_t force_y;
  axis_t force_z;
  axis_t torque_x;
  axis_t torque_y;
  axis_t torque_z;

  modport source (output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                  input ready);
  modport sink (input valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                output ready);
endinterface

interface ftaz_result_if;
  import ftaz_pkg::*;
  logic  valid;
  logic  ready;
  axis_t out_force_x;
  axis_t out_force_y;
  axis_t out_force_z;
  axis_t out_torque_x;
  axis_t out_torque_y;
  axis_t out_torque_z;
  logic  bias_ready;
  logic  calib_error;

  modport source (output valid, out_force_x, out_force_y, out_force_z, out_torque_x,
                  out_torque_y, out_torque_z, bias_ready, calib_error, input ready);
  modport sink (input valid, out_force_x, out_force_y, out_force_z, out_torque_x,
                out_torque_y, out_torque_z, bias_ready, calib_error, output ready);
endinterface

interface ftaz_cfg_if;
  import ftaz_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ft_auto_zero_stability_bias.sv =====
// an accepted sample's result is in the output register from the next cycle on
// throughput: one sample per cycle unless stalled; six lanes and merge are combinational
// a new sample is taken whenever the output register is empty or being drained
// reset (rst, synchronous): bias and previous sample cleared, counters and flags cleared,
// configuration registers cleared (calibration disabled), output register empty
module ft_auto_zero_stability_bias import ftaz_pkg::*; (
  input logic           clk,
  input logic           rst,
  ftaz_sample_if.sink   sample,
  ftaz_result_if.source result,
  ftaz_cfg_if.sink      cfg
);

  logic [SCOUNT_W-1:0] sample_count;
  logic [TOL_W-1:0]    stable_tolerance;
  logic [THR_W-1:0]    zero_threshold;

  axes_t                       raw;
  axes_t                       corr;
  axes_t                       out_axes;
  lane_stat_t [AXIS_COUNT-1:0] stat;
  lane_ctl_t                   ctl;
  logic                        fire;
  logic                        done_next;
  logic                        err_next;
  logic                        out_valid;
  logic                        out_done;
  logic                        out_err;

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count     <= '0;
      stable_tolerance <= '0;
      zero_threshold   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SAMPLE_COUNT:     sample_count     <= cfg.data[SCOUNT_W-1:0];
        REG_STABLE_TOLERANCE: stable_tolerance <= cfg.data[TOL_W-1:0];
        REG_ZERO_THRESHOLD:   zero_threshold   <= cfg.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // input transaction
  assign sample.ready = !out_valid || result.ready;
  assign fire         = sample.valid && sample.ready;

  assign raw[0] = sample.force_x;
  assign raw[1] = sample.force_y;
  assign raw[2] = sample.force_z;
  assign raw[3] = sample.torque_x;
  assign raw[4] = sample.torque_y;
  assign raw[5] = sample.torque_z;

  // axis lanes
  for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_lane
    ftaz_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .raw       (raw[g]),
      .tolerance (stable_tolerance),
      .threshold (zero_threshold),
      .ctl       (ctl),
      .corr      (corr[g]),
      .stat      (stat[g])
    );
  end

  // counters and flags
  ftaz_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .sample_count (sample_count),
    .stat         (stat),
    .ctl          (ctl),
    .done_next    (done_next),
    .err_next     (err_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_axes <= corr;
      out_done <= done_next;
      out_err  <= err_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.out_force_x  = out_axes[0];
  assign result.out_force_y  = out_axes[1];
  assign result.out_force_z  = out_axes[2];
  assign result.out_torque_x = out_axes[3];
  assign result.out_torque_y = out_axes[4];
  assign result.out_torque_z = out_axes[5];
  assign result.bias_ready   = out_done;
  assign result.calib_error  = out_err;

endmodule

// ===== hw/rtl/ftaz_lane.sv =====
module ftaz_lane import ftaz_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  axis_t            raw,
  input  logic [TOL_W-1:0] tolerance,
  input  logic [THR_W-1:0] threshold,
  input  lane_ctl_t        ctl,
  output axis_t            corr,
  output lane_stat_t       stat
);

  axis_t bias;
  axis_t prev;

  logic [AXIS_W:0]   diff;
  logic [AXIS_W-1:0] corr_mag;
  logic [AXIS_W:0]   delta;
  logic [AXIS_W:0]   delta_mag;

  // bias subtraction with saturation to 32 bits
  always_comb begin
    diff = {raw[AXIS_W-1], raw} - {bias[AXIS_W-1], bias};
    if (diff[AXIS_W] != diff[AXIS_W-1]) begin
      corr = diff[AXIS_W] ? {1'b1, {(AXIS_W-1){1'b0}}} : {1'b0, {(AXIS_W-1){1'b1}}};
    end else begin
      corr = diff[AXIS_W-1:0];
    end
  end

  // magnitude and step size checks
  always_comb begin
    corr_mag  = corr[AXIS_W-1] ? (~corr + 1'b1) : corr;
    delta     = {corr[AXIS_W-1], corr} - {prev[AXIS_W-1], prev};
    delta_mag = delta[AXIS_W] ? (~delta + 1'b1) : delta;
    stat.nonzero = corr_mag > {{(AXIS_W-THR_W){1'b0}}, threshold};
    stat.far     = delta_mag > {{(AXIS_W+1-TOL_W){1'b0}}, tolerance};
  end

  // per-axis state
  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
      prev <= '0;
    end else begin
      if (ctl.upd_prev) prev <= corr;
      if (ctl.cap_bias) bias <= corr;
    end
  end

endmodule

// ===== hw/rtl/ftaz_merge.sv =====
module ftaz_merge import ftaz_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [SCOUNT_W-1:0]           sample_count,
  input  lane_stat_t [AXIS_COUNT-1:0]   stat,
  output lane_ctl_t                     ctl,
  output logic                          done_next,
  output logic                          err_next
);

  logic [STABLE_W-1:0]  stable_count;
  logic [STABLE_W-1:0]  stable_count_next;
  logic [ATTEMPT_W-1:0] attempt_count;
  logic [ATTEMPT_W-1:0] attempt_count_next;
  logic                 done;
  logic                 err;

  logic                 active;
  logic                 any_nonzero;
  logic                 any_far;
  logic [ATTEMPT_W-1:0] attempt_limit;
  logic                 over;

  // combine lane findings and decide the calibration step
  always_comb begin
    any_nonzero = 1'b0;
    any_far     = 1'b0;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      any_nonzero = any_nonzero | stat[i].nonzero;
      any_far     = any_far | stat[i].far;
    end
    active        = (sample_count != '0) && !done && !err;
    attempt_limit = ATTEMPT_W'(sample_count) + ATTEMPT_W'(ATTEMPT_MARGIN);
    over          = attempt_count > attempt_limit;

    stable_count_next  = stable_count;
    attempt_count_next = attempt_count;
    done_next          = done;
    err_next           = err;
    ctl                = '0;
    if (active) begin
      if (any_nonzero && !any_far) begin
        if (stable_count != '1) stable_count_next = stable_count + 1'b1;
      end else begin
        stable_count_next = '0;
      end
      ctl.upd_prev = fire;
      if (over) begin
        err_next = 1'b1;
      end else begin
        if (stable_count_next >= STABLE_W'(sample_count)) begin
          ctl.cap_bias = fire;
          done_next    = 1'b1;
        end
        if (attempt_count != '1) attempt_count_next = attempt_count + 1'b1;
      end
    end
  end

  // calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_count  <= '0;
      attempt_count <= '0;
      done          <= 1'b0;
      err           <= 1'b0;
    end else if (fire) begin
      stable_count  <= stable_count_next;
      attempt_count <= attempt_count_next;
      done          <= done_next;
      err           <= err_next;
    end
  end

endmodule
